// File: src/plob_pkg.sv
`default_nettype none

package plob_pkg;

    localparam int BOOKS_DEF   = 16;
    localparam int LEVELS_DEF  = 32;
    localparam int SLOT_IN_W   = 4;
    localparam int PRICE_W     = 64;
    localparam int SIZE_W      = 32;
    localparam int STAT_W      = 32;
    localparam int LEVEL_W     = PRICE_W + SIZE_W;

    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;

    typedef struct packed {
        logic [SLOT_IN_W-1:0]      book_slot;
        logic                      side;
        logic signed [PRICE_W-1:0] level_price;
        logic [SIZE_W-1:0]         level_size;
        logic                      evt_last;
    } t_in_item;

    typedef struct packed {
        logic                      bid_valid;
        logic signed [PRICE_W-1:0] best_bid_price;
        logic [SIZE_W-1:0]         best_bid_size;
        logic                      ask_valid;
        logic signed [PRICE_W-1:0] best_ask_price;
        logic [SIZE_W-1:0]         best_ask_size;
        logic                      stable;
        logic                      insert_dropped;
        logic [STAT_W-1:0]         update_count;
        logic [STAT_W-1:0]         delete_count;
        logic [STAT_W-1:0]         crossed_count;
        logic [STAT_W-1:0]         locked_count;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_SCAN,
        S_DECIDE,
        S_DMOVE,
        S_IMOVE,
        S_IPUT,
        S_MWR,
        S_RB,
        S_RA,
        S_OUT
    } t_state;

    function automatic logic price_lt(input logic [PRICE_W-1:0] a,
                                      input logic [PRICE_W-1:0] b);
        price_lt = $signed(a) < $signed(b);
    endfunction

endpackage

`default_nettype wire

// File: src/plob_if.sv
`default_nettype none

interface plob_in_if import plob_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface plob_out_if import plob_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/plob_ram.sv
`default_nettype none

module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/plob_ctrl.sv
`default_nettype none

module plob_ctrl import plob_pkg::*; #(
    parameter int BOOKS           = BOOKS_DEF,
    parameter int LEVELS_PER_SIDE = LEVELS_DEF,
    localparam int SLOT_W = (BOOKS > 1) ? $clog2(BOOKS) : 1,
    localparam int LVL_W  = $clog2(LEVELS_PER_SIDE),
    localparam int CNT_W  = $clog2(LEVELS_PER_SIDE + 1),
    localparam int LA_W   = 1 + SLOT_W + LVL_W,
    localparam int META_W = 2 * CNT_W + 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    plob_in_if.sink                i_in,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output t_result                o_res,
    output logic                   o_lv_we,
    output logic [LA_W-1:0]        o_lv_waddr,
    output logic [LEVEL_W-1:0]     o_lv_wdata,
    output logic [LA_W-1:0]        o_lv_raddr,
    input  wire logic [LEVEL_W-1:0] i_lv_rdata,
    output logic                   o_mt_we,
    output logic [SLOT_W-1:0]      o_mt_waddr,
    output logic [META_W-1:0]      o_mt_wdata,
    output logic [SLOT_W-1:0]      o_mt_raddr,
    input  wire logic [META_W-1:0] i_mt_rdata
);

    t_state r_state, n_state;

    logic [SLOT_W-1:0]  r_clr;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_side;
    logic [PRICE_W-1:0] r_price;
    logic [SIZE_W-1:0]  r_size;
    logic               r_done;
    logic [CNT_W-1:0]   r_n, r_idx, r_pos, r_bcnt, r_acnt;
    logic               r_hit, r_drop;
    logic [PRICE_W-1:0] r_bp;
    logic [SIZE_W-1:0]  r_bs;
    logic [STAT_W-1:0]  r_upd, r_del, r_crs, r_lck;
    t_result            r_res;

    logic [SLOT_W-1:0]  slot_map;
    logic [PRICE_W-1:0] rd_price;
    logic [SIZE_W-1:0]  rd_size;
    logic [CNT_W-1:0]   m_bcnt, m_acnt, meta_n;
    logic               s_eq, s_lt, s_last, size_zero;
    logic               bv, av, crs, lck;
    logic [PRICE_W-1:0] ap, bp;
    logic [SIZE_W-1:0]  as_v, bs_v;
    logic [STAT_W-1:0]  upd_nx, del_nx, crs_nx, lck_nx;

    // book slot reduced modulo the number of books
    always_comb begin
        slot_map = '0;
        for (int k = 0; k < (1 << SLOT_IN_W); k++) begin
            if (i_in.data.book_slot == SLOT_IN_W'(k)) begin
                slot_map = SLOT_W'(k % BOOKS);
            end
        end
    end

    assign rd_price  = i_lv_rdata[LEVEL_W-1:SIZE_W];
    assign rd_size   = i_lv_rdata[SIZE_W-1:0];
    assign m_bcnt    = i_mt_rdata[META_W-1:CNT_W+1];
    assign m_acnt    = i_mt_rdata[CNT_W:1];
    assign meta_n    = r_side ? m_acnt : m_bcnt;
    assign s_eq      = rd_price == r_price;
    assign s_lt      = price_lt(r_price, rd_price);
    assign s_last    = CNT_W'(r_idx + 1'b1) == r_n;
    assign size_zero = r_size == '0;

    assign bv   = r_bcnt != '0;
    assign av   = r_acnt != '0;
    assign bp   = bv ? r_bp : '0;
    assign bs_v = bv ? r_bs : '0;
    assign ap   = av ? rd_price : '0;
    assign as_v = av ? rd_size : '0;
    assign crs  = bv && av && r_done && price_lt(ap, bp);
    assign lck  = bv && av && r_done && (ap == bp);

    assign upd_nx = r_upd + 1'b1;
    assign del_nx = size_zero ? r_del + 1'b1 : r_del;
    assign crs_nx = crs ? r_crs + 1'b1 : r_crs;
    assign lck_nx = lck ? r_lck + 1'b1 : r_lck;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == SLOT_W'(BOOKS - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_in.valid) n_state = S_META;
            S_META:   n_state = (meta_n == '0) ? S_DECIDE : S_SCAN;
            S_SCAN:   if (s_eq || s_lt || s_last) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_hit) begin
                    if (!size_zero || CNT_W'(r_pos + 1'b1) >= r_n) begin
                        n_state = S_MWR;
                    end else begin
                        n_state = S_DMOVE;
                    end
                end else if (size_zero || r_n == CNT_W'(LEVELS_PER_SIDE)) begin
                    n_state = S_MWR;
                end else if (r_n > r_pos) begin
                    n_state = S_IMOVE;
                end else begin
                    n_state = S_IPUT;
                end
            end
            S_DMOVE:  if (CNT_W'(r_idx + 2'd2) >= r_n) n_state = S_MWR;
            S_IMOVE:  if (r_idx <= CNT_W'(r_pos + 1'b1)) n_state = S_IPUT;
            S_IPUT:   n_state = S_MWR;
            S_MWR:    n_state = S_RB;
            S_RB:     n_state = S_RA;
            S_RA:     n_state = S_OUT;
            S_OUT:    if (i_res_take) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        o_lv_we     = 1'b0;
        o_lv_waddr  = '0;
        o_lv_wdata  = i_lv_rdata;
        o_lv_raddr  = '0;
        o_mt_we     = 1'b0;
        o_mt_waddr  = r_slot;
        o_mt_wdata  = {r_bcnt, r_acnt, r_done};
        o_mt_raddr  = slot_map;
        i_in.ready  = r_state == S_IDLE;
        o_res_valid = r_state == S_OUT;
        unique case (r_state)
            S_CLEAR: begin
                o_mt_we    = 1'b1;
                o_mt_waddr = r_clr;
                o_mt_wdata = '0;
            end
            S_META: o_lv_raddr = {r_side, r_slot, LVL_W'(0)};
            S_SCAN: o_lv_raddr = {r_side, r_slot, LVL_W'(r_idx + 1'b1)};
            S_DECIDE: begin
                if (r_hit && !size_zero) begin
                    o_lv_we    = 1'b1;
                    o_lv_waddr = {r_side, r_slot, r_pos[LVL_W-1:0]};
                    o_lv_wdata = {r_price, r_size};
                end else if (r_hit) begin
                    o_lv_raddr = {r_side, r_slot, LVL_W'(r_pos + 1'b1)};
                end else begin
                    o_lv_raddr = {r_side, r_slot, LVL_W'(r_n - 1'b1)};
                end
            end
            S_DMOVE: begin
                o_lv_we    = 1'b1;
                o_lv_waddr = {r_side, r_slot, r_idx[LVL_W-1:0]};
                o_lv_raddr = {r_side, r_slot, LVL_W'(r_idx + 2'd2)};
            end
            S_IMOVE: begin
                o_lv_we    = 1'b1;
                o_lv_waddr = {r_side, r_slot, r_idx[LVL_W-1:0]};
                o_lv_raddr = {r_side, r_slot, LVL_W'(r_idx - 2'd2)};
            end
            S_IPUT: begin
                o_lv_we    = 1'b1;
                o_lv_waddr = {r_side, r_slot, r_pos[LVL_W-1:0]};
                o_lv_wdata = {r_price, r_size};
            end
            S_MWR: begin
                o_mt_we    = 1'b1;
                o_lv_raddr = {SIDE_BID, r_slot, LVL_W'(r_bcnt - 1'b1)};
            end
            S_RB: o_lv_raddr = {SIDE_ASK, r_slot, LVL_W'(0)};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_upd   <= '0;
            r_del   <= '0;
            r_crs   <= '0;
            r_lck   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_slot  <= slot_map;
                        r_side  <= i_in.data.side;
                        r_price <= i_in.data.level_price;
                        r_size  <= i_in.data.level_size;
                        r_done  <= i_in.data.evt_last;
                    end
                end
                S_META: begin
                    r_bcnt <= m_bcnt;
                    r_acnt <= m_acnt;
                    r_n    <= meta_n;
                    r_idx  <= '0;
                    r_pos  <= '0;
                    r_hit  <= 1'b0;
                    r_drop <= 1'b0;
                end
                S_SCAN: begin
                    if (s_eq) begin
                        r_hit <= 1'b1;
                        r_pos <= r_idx;
                    end else if (s_lt) begin
                        r_pos <= r_idx;
                    end else if (s_last) begin
                        r_pos <= r_n;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DECIDE: begin
                    if (r_hit && size_zero) begin
                        r_idx <= r_pos;
                        if (r_side) r_acnt <= r_acnt - 1'b1;
                        else        r_bcnt <= r_bcnt - 1'b1;
                    end else if (!r_hit && !size_zero) begin
                        if (r_n == CNT_W'(LEVELS_PER_SIDE)) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_idx <= r_n;
                            if (r_side) r_acnt <= r_acnt + 1'b1;
                            else        r_bcnt <= r_bcnt + 1'b1;
                        end
                    end
                end
                S_DMOVE: r_idx <= r_idx + 1'b1;
                S_IMOVE: r_idx <= r_idx - 1'b1;
                S_RB: begin
                    r_bp <= rd_price;
                    r_bs <= rd_size;
                end
                S_RA: begin
                    r_upd <= upd_nx;
                    r_del <= del_nx;
                    r_crs <= crs_nx;
                    r_lck <= lck_nx;
                    r_res <= '{bid_valid: bv, best_bid_price: bp, best_bid_size: bs_v,
                               ask_valid: av, best_ask_price: ap, best_ask_size: as_v,
                               stable: r_done, insert_dropped: r_drop,
                               update_count: upd_nx, delete_count: del_nx,
                               crossed_count: crs_nx, locked_count: lck_nx};
                end
                default: ;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: src/price_level_order_book.sv
`default_nettype none

// channel  dir  handshake       payload
// i_in     in   valid / ready   book_slot, side, level_price, level_size, evt_last
// o_out    out  valid / ready   best bid/ask, stable, insert_dropped, four counters
//
// an update is processed to the end before the next one can be taken: one level
// memory read a cycle for the sorted scan up to the level's position, then one read
// and one write a cycle to shift the levels behind it on insert or delete.
// after reset the book state memory is cleared, one book a cycle, with i_in.ready
// low. the output register lets the next update start while a result waits on
// o_out.ready.

module price_level_order_book import plob_pkg::*; #(
    parameter int BOOKS           = BOOKS_DEF,
    parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    plob_in_if.sink    i_in,
    plob_out_if.source o_out
);

    localparam int SLOT_W = (BOOKS > 1) ? $clog2(BOOKS) : 1;
    localparam int LVL_W  = $clog2(LEVELS_PER_SIDE);
    localparam int CNT_W  = $clog2(LEVELS_PER_SIDE + 1);
    localparam int LA_W   = 1 + SLOT_W + LVL_W;
    localparam int META_W = 2 * CNT_W + 1;

    logic               lv_we;
    logic [LA_W-1:0]    lv_waddr, lv_raddr;
    logic [LEVEL_W-1:0] lv_wdata, lv_rdata;
    logic               mt_we;
    logic [SLOT_W-1:0]  mt_waddr, mt_raddr;
    logic [META_W-1:0]  mt_wdata, mt_rdata;
    logic               res_valid, res_take;
    t_result            res;
    logic               r_out_valid;
    t_result            r_out;

    plob_ram #(.WIDTH(LEVEL_W), .DEPTH(1 << LA_W)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (lv_we),
        .i_waddr (lv_waddr),
        .i_wdata (lv_wdata),
        .i_raddr (lv_raddr),
        .o_rdata (lv_rdata)
    );

    plob_ram #(.WIDTH(META_W), .DEPTH(BOOKS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (mt_we),
        .i_waddr (mt_waddr),
        .i_wdata (mt_wdata),
        .i_raddr (mt_raddr),
        .o_rdata (mt_rdata)
    );

    plob_ctrl #(.BOOKS(BOOKS), .LEVELS_PER_SIDE(LEVELS_PER_SIDE)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_lv_we     (lv_we),
        .o_lv_waddr  (lv_waddr),
        .o_lv_wdata  (lv_wdata),
        .o_lv_raddr  (lv_raddr),
        .i_lv_rdata  (lv_rdata),
        .o_mt_we     (mt_we),
        .o_mt_waddr  (mt_waddr),
        .o_mt_wdata  (mt_wdata),
        .o_mt_raddr  (mt_raddr),
        .i_mt_rdata  (mt_rdata)
    );

    assign res_take = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("update accepted while another is in flight");

    a_empty_bid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.bid_valid) |->
            (o_out.data.best_bid_price == '0 && o_out.data.best_bid_size == '0))
        else $error("empty bid side reports nonzero level");

    a_empty_ask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.ask_valid) |->
            (o_out.data.best_ask_price == '0 && o_out.data.best_ask_size == '0))
        else $error("empty ask side reports nonzero level");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import plob_pkg::*;

    localparam int NBOOKS = BOOKS_DEF;
    localparam int NLEV   = LEVELS_DEF;
    localparam int IDLE_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    plob_in_if  in_ch ();
    plob_out_if out_ch ();

    price_level_order_book dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // shadow book state
    logic signed [PRICE_W-1:0] bk_price [NBOOKS][NLEV];
    logic [SIZE_W-1:0]         bk_size  [NBOOKS][NLEV];
    int                        bk_count [NBOOKS];
    logic signed [PRICE_W-1:0] ak_price [NBOOKS][NLEV];
    logic [SIZE_W-1:0]         ak_size  [NBOOKS][NLEV];
    int                        ak_count [NBOOKS];
    logic                      bk_done  [NBOOKS];
    logic [STAT_W-1:0]         n_upd, n_del, n_cross, n_lock;

    t_in_item pending_updates [$];
    t_result  expected_tops   [$];
    int  errors = 0;
    bit  stim_done = 1'b0;
    bit  hold_for_drain = 1'b0;

    // applies one level change to a sorted side, returns 1 on a dropped insert
    function automatic bit apply_level(ref logic signed [PRICE_W-1:0] pr [NBOOKS][NLEV],
                                       ref logic [SIZE_W-1:0] sz [NBOOKS][NLEV],
                                       ref int cnt [NBOOKS], input int b,
                                       input logic signed [PRICE_W-1:0] p,
                                       input logic [SIZE_W-1:0] s);
        int n;
        int pos;
        bit hit;
        n = cnt[b];
        pos = n;
        hit = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (pr[b][i] == p) begin
                hit = 1'b1;
                pos = i;
                break;
            end
            if (p < pr[b][i]) begin
                pos = i;
                break;
            end
        end
        if (hit) begin
            if (s == 0) begin
                for (int i = pos; i + 1 < n; i++) begin
                    pr[b][i] = pr[b][i+1];
                    sz[b][i] = sz[b][i+1];
                end
                cnt[b] = n - 1;
            end else begin
                sz[b][pos] = s;
            end
            return 1'b0;
        end
        if (s == 0) return 1'b0;
        if (n >= NLEV) return 1'b1;
        for (int i = n; i > pos; i--) begin
            pr[b][i] = pr[b][i-1];
            sz[b][i] = sz[b][i-1];
        end
        pr[b][pos] = p;
        sz[b][pos] = s;
        cnt[b] = n + 1;
        return 1'b0;
    endfunction

    function automatic t_result book_update(input t_in_item it);
        t_result r;
        int b;
        b = int'(it.book_slot) % NBOOKS;
        r = '0;
        n_upd++;
        if (it.level_size == 0) n_del++;
        if (it.side == SIDE_BID)
            r.insert_dropped = apply_level(bk_price, bk_size, bk_count, b,
                                           it.level_price, it.level_size);
        else
            r.insert_dropped = apply_level(ak_price, ak_size, ak_count, b,
                                           it.level_price, it.level_size);
        bk_done[b] = it.evt_last;
        r.bid_valid = bk_count[b] > 0;
        r.ask_valid = ak_count[b] > 0;
        if (r.bid_valid) begin
            r.best_bid_price = bk_price[b][bk_count[b]-1];
            r.best_bid_size  = bk_size[b][bk_count[b]-1];
        end
        if (r.ask_valid) begin
            r.best_ask_price = ak_price[b][0];
            r.best_ask_size  = ak_size[b][0];
        end
        if (r.bid_valid && r.ask_valid && it.evt_last) begin
            if (r.best_ask_price < r.best_bid_price) n_cross++;
            else if (r.best_ask_price == r.best_bid_price) n_lock++;
        end
        r.stable = it.evt_last;
        r.update_count = n_upd;
        r.delete_count = n_del;
        r.crossed_count = n_cross;
        r.locked_count = n_lock;
        return r;
    endfunction

    function automatic t_in_item mk(input int b, input bit sd, input longint p,
                                    input logic [31:0] s, input bit d);
        t_in_item it;
        it.book_slot = b[3:0];
        it.side = sd;
        it.level_price = p;
        it.level_size = s;
        it.evt_last = d;
        return it;
    endfunction

    // driver: bursts with random gaps
    int gap_left = 0;
    int burst_left = 0;
    int n_in_acc = 0;
    int n_in_pop = 0;
    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        bit taken;
        // the monitor counts transfers at the rising edge
        taken = n_in_pop != n_in_acc;
        if (taken) begin
            void'(pending_updates.pop_front());
            n_in_pop++;
        end
        if (!i_rst_n || hold_for_drain) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !taken) begin
            in_ch.valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            in_ch.valid <= 1'b0;
        end else if (pending_updates.size() > 0) begin
            in_ch.valid <= 1'b1;
            in_ch.data <= pending_updates[0];
            if (burst_left > 0) burst_left--;
            else begin
                burst_left = $urandom_range(0, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase++;
        if (stall_phase % 600 < 200) out_ch.ready <= 1'b1;
        else if (stall_phase % 600 < 400) out_ch.ready <= ($urandom_range(0, 3) != 0);
        else out_ch.ready <= ($urandom_range(0, 4) == 0);
    end

    // monitor
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        t_result e;
        t_result a;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_tops.push_back(book_update(in_ch.data));
                n_in_acc++;
            end
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.data;
                if (expected_tops.size() == 0) begin
                    $display("%0t unexpected result %h", $time, a);
                    errors++;
                end else begin
                    e = expected_tops.pop_front();
                    if (a !== e) begin
                        errors++;
                        $display("%0t mismatch expected %h actual %h", $time, e, a);
                        if (a.bid_valid !== e.bid_valid || a.best_bid_price !== e.best_bid_price
                            || a.best_bid_size !== e.best_bid_size)
                            $display("%0t  bid exp %b %0d %0d act %b %0d %0d", $time,
                                     e.bid_valid, e.best_bid_price, e.best_bid_size,
                                     a.bid_valid, a.best_bid_price, a.best_bid_size);
                        if (a.ask_valid !== e.ask_valid || a.best_ask_price !== e.best_ask_price
                            || a.best_ask_size !== e.best_ask_size)
                            $display("%0t  ask exp %b %0d %0d act %b %0d %0d", $time,
                                     e.ask_valid, e.best_ask_price, e.best_ask_size,
                                     a.ask_valid, a.best_ask_price, a.best_ask_size);
                        if (a.stable !== e.stable || a.insert_dropped !== e.insert_dropped)
                            $display("%0t  flags exp %b%b act %b%b", $time, e.stable,
                                     e.insert_dropped, a.stable, a.insert_dropped);
                        if ({a.update_count, a.delete_count, a.crossed_count, a.locked_count}
                            !== {e.update_count, e.delete_count, e.crossed_count, e.locked_count})
                            $display("%0t  counts exp %0d %0d %0d %0d act %0d %0d %0d %0d",
                                     $time, e.update_count, e.delete_count, e.crossed_count,
                                     e.locked_count, a.update_count, a.delete_count,
                                     a.crossed_count, a.locked_count);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[price_level_order_book] ERROR");
                $finish;
            end
        end
    end

    task automatic add_random(input int count);
        int b;
        bit sd;
        longint p;
        logic [31:0] s;
        for (int k = 0; k < count; k++) begin
            b = $urandom_range(0, 15);
            sd = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0: p = {$urandom, $urandom};
                1: p = (b == 3) ? $urandom_range(0, 63) : 1000 + $urandom_range(0, 40);
                default: p = 1000 + $urandom_range(0, 40) - (sd ? 0 : 10);
            endcase
            case ($urandom_range(0, 7))
                0, 1: s = 0;
                2: s = $urandom;
                3: s = 32'hffff_ffff;
                default: s = $urandom_range(1, 500);
            endcase
            pending_updates.push_back(mk(b, sd, p, s, $urandom_range(0, 3) != 0));
        end
    endtask

    initial begin
        n_upd = 0; n_del = 0; n_cross = 0; n_lock = 0;
        for (int b = 0; b < NBOOKS; b++) begin
            bk_count[b] = 0;
            ak_count[b] = 0;
            bk_done[b] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, replace, delete, absent delete, lock, cross, full side
        pending_updates.push_back(mk(0, SIDE_BID, 64'sh7fff_ffff_ffff_ffff, 32'hffff_ffff, 1));
        pending_updates.push_back(mk(0, SIDE_ASK, 64'sh8000_0000_0000_0000, 1, 1));
        pending_updates.push_back(mk(0, SIDE_BID, -5, 7, 0));
        pending_updates.push_back(mk(0, SIDE_BID, 64'sh7fff_ffff_ffff_ffff, 9, 1));
        pending_updates.push_back(mk(0, SIDE_BID, 64'sh7fff_ffff_ffff_ffff, 0, 1));
        pending_updates.push_back(mk(0, SIDE_ASK, 123, 0, 1));
        pending_updates.push_back(mk(0, SIDE_ASK, 64'sh8000_0000_0000_0000, 0, 0));
        pending_updates.push_back(mk(15, SIDE_BID, 100, 5, 1));
        pending_updates.push_back(mk(15, SIDE_ASK, 100, 6, 1));
        pending_updates.push_back(mk(15, SIDE_ASK, 90, 6, 1));
        pending_updates.push_back(mk(15, SIDE_ASK, 80, 6, 0));
        for (int i = 0; i < NLEV + 2; i++)
            pending_updates.push_back(mk(7, SIDE_ASK, 500 - 3 * i, i + 1, i[0]));
        pending_updates.push_back(mk(7, SIDE_ASK, 500, 0, 1));
        pending_updates.push_back(mk(7, SIDE_ASK, 1, 2, 1));

        add_random(1000);
        // drain pause
        wait (pending_updates.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_tops.size() == 0);
        repeat (20) @(posedge i_clk);
        hold_for_drain = 1'b0;
        add_random(1000);
        wait (pending_updates.size() == 0);
        wait (expected_tops.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_tops.size() == 0) begin
            $display("[price_level_order_book] OK");
        end else begin
            $display("[price_level_order_book] ERROR");
        end
        $finish;
    end
endmodule

// File: price_level_order_book.f
src/plob_pkg.sv
src/plob_if.sv
src/plob_ram.sv
src/plob_ctrl.sv
src/price_level_order_book.sv
sim/testbench.sv
